// ===== hw/rtl/sst_pkg.sv =====
// shared types and constants for the sorted set table
`default_nettype none

package sst_pkg;

    // request kinds carried in the slave-side tuser
    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam int ElemWidth = 32;
    localparam int CapWidth  = 7;
    localparam int PosWidth  = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_DECIDE,
        ST_SHIFT,
        ST_PLACE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic probe;
        logic compare;
        logic decide;
        logic shift;
        logic place;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_active;
        logic ins_do;
        logic rem_do;
        logic ins_shift;
        logic rem_shift;
        logic shift_busy;
        logic insert_pending;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sst_ram.sv =====
// generic single write, single read port ram with registered read data
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_ctrl.sv =====
// controller state machine: search, shift and result sequencing
`default_nettype none

module sst_ctrl import sst_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_active)
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_SEARCH;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (status.ins_do)
                begin
                    state_next = status.ins_shift ? ST_SHIFT : ST_PLACE;
                end
                else if (status.rem_do)
                begin
                    state_next = status.rem_shift ? ST_SHIFT : ST_FINISH;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (!status.shift_busy)
                begin
                    state_next = status.insert_pending ? ST_PLACE : ST_FINISH;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a probe is only ever issued from the search state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |=> (state_reg == ST_COMPARE))
        else $error("probe not followed by compare");

endmodule

`default_nettype wire

// ===== hw/rtl/sst_datapath.sv =====
// datapath: search bounds, entry memory, shift engine, count and result register
`default_nettype none

module sst_datapath import sst_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    input  wire logic [ElemWidth-1:0] in_element,
    input  wire logic [1:0]           in_action,
    input  wire logic                 cfg_we,
    input  wire logic [CapWidth-1:0]  cfg_wdata,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      out_success,
    output logic                      out_present,
    output logic [PosWidth-1:0]       out_position,
    output logic [CapWidth-1:0]       out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CapWidth) ? CW : CapWidth;

    // control state
    logic [CW-1:0]       count_reg, count_next;
    logic [CapWidth-1:0] capacity_reg, capacity_next;
    logic                found_reg, found_next;
    logic                ins_do_reg, ins_do_next;
    logic                rem_do_reg, rem_do_next;
    logic                rd_active_reg, rd_active_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [1:0]                action_reg, action_next;
    logic signed [ElemWidth-1:0] key_reg, key_next;
    logic [CW-1:0]             lo_reg, lo_next;
    logic [CW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             where_reg, where_next;
    logic                      success_reg, success_next;
    logic                      present_reg, present_next;
    logic                      posv_reg, posv_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]             rd_end_reg, rd_end_next;
    logic [AW-1:0]             wr_addr_reg, wr_addr_next;
    logic                      out_success_reg, out_success_next;
    logic                      out_present_reg, out_present_next;
    logic [PosWidth-1:0]       out_pos_reg, out_pos_next;
    logic [CapWidth-1:0]       out_count_reg, out_count_next;

    logic [CW:0]           mid_sum;
    logic [AW-1:0]         mid;
    logic [CW-1:0]         eff_where;
    logic                  full;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ElemWidth-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ElemWidth-1:0]  ram_rdata;
    logic signed [ElemWidth-1:0] probe_val;

    sst_ram #(
        .WIDTH (ElemWidth),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = AW'(mid_sum >> 1);
    assign eff_where = found_reg ? where_reg : lo_reg;
    assign probe_val = $signed(ram_rdata);
    // limit is min(capacity, depth)
    assign full      = (LW'(count_reg) >= LW'(capacity_reg)) || (count_reg == CW'(DEPTH));

    always_comb
    begin
        status.search_active  = (action_reg != 2'd3) && !found_reg && (lo_reg < hi_reg);
        status.ins_do         = (action_reg == ACT_INSERT) && !full && !found_reg;
        status.rem_do         = (action_reg == ACT_REMOVE) && found_reg;
        status.ins_shift      = eff_where != count_reg;
        status.rem_shift      = (where_reg + CW'(1)) < count_reg;
        status.shift_busy     = rd_active_reg || pend_reg;
        status.insert_pending = ins_do_reg;
        status.out_free       = !out_valid_reg || out_ready;
    end

    // memory port steering
    always_comb
    begin
        ram_re    = cmd.probe || (cmd.shift && rd_active_reg);
        ram_raddr = cmd.probe ? mid : rd_ptr_reg;
        ram_we    = (cmd.shift && pend_reg) || cmd.place;
        ram_waddr = cmd.place ? AW'(where_reg) : wr_addr_reg;
        ram_wdata = cmd.place ? key_reg : ram_rdata;
    end

    always_comb
    begin
        count_next       = count_reg;
        capacity_next    = cfg_we ? cfg_wdata : capacity_reg;
        found_next       = found_reg;
        ins_do_next      = ins_do_reg;
        rem_do_next      = rem_do_reg;
        rd_active_next   = rd_active_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        action_next      = action_reg;
        key_next         = key_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        where_next       = where_reg;
        success_next     = success_reg;
        present_next     = present_reg;
        posv_next        = posv_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_end_next      = rd_end_reg;
        wr_addr_next     = wr_addr_reg;
        out_success_next = out_success_reg;
        out_present_next = out_present_reg;
        out_pos_next     = out_pos_reg;
        out_count_next   = out_count_reg;

        if (cmd.load)
        begin
            action_next = in_action;
            key_next    = $signed(in_element);
            lo_next     = '0;
            hi_next     = count_reg;
            found_next  = 1'b0;
        end

        if (cmd.compare)
        begin
            priority if (probe_val == key_reg)
            begin
                found_next = 1'b1;
                where_next = CW'(mid);
            end
            else if (key_reg > probe_val)
            begin
                lo_next = CW'(mid) + CW'(1);
            end
            else
            begin
                hi_next = CW'(mid);
            end
        end

        if (cmd.decide)
        begin
            where_next  = eff_where;
            ins_do_next = status.ins_do;
            rem_do_next = status.rem_do;
            unique case (action_reg)
                ACT_QUERY:
                begin
                    success_next = found_reg;
                    present_next = found_reg;
                    posv_next    = found_reg;
                end
                ACT_INSERT:
                begin
                    success_next = !full;
                    present_next = found_reg;
                    posv_next    = found_reg || !full;
                end
                ACT_REMOVE:
                begin
                    success_next = found_reg;
                    present_next = found_reg;
                    posv_next    = found_reg;
                end
                default:
                begin
                    success_next = 1'b0;
                    present_next = 1'b0;
                    posv_next    = 1'b0;
                end
            endcase
            // insert walks down from the top, remove walks up from the hole
            rd_active_next = 1'b0;
            if (status.ins_do)
            begin
                rd_ptr_next    = AW'(count_reg - CW'(1));
                rd_end_next    = AW'(eff_where);
                rd_active_next = status.ins_shift;
            end
            else if (status.rem_do)
            begin
                rd_ptr_next    = AW'(where_reg + CW'(1));
                rd_end_next    = AW'(count_reg - CW'(1));
                rd_active_next = status.rem_shift;
            end
        end

        if (cmd.shift)
        begin
            pend_next = rd_active_reg;
            if (rd_active_reg)
            begin
                wr_addr_next = ins_do_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                if (rd_ptr_reg == rd_end_reg)
                begin
                    rd_active_next = 1'b0;
                end
                else
                begin
                    rd_ptr_next = ins_do_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                end
            end
        end

        if (cmd.finish)
        begin
            priority if (ins_do_reg)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (rem_do_reg)
            begin
                count_next = count_reg - CW'(1);
            end
            else
            begin
                count_next = count_reg;
            end
            out_valid_next   = 1'b1;
            out_success_next = success_reg;
            out_present_next = present_reg;
            out_pos_next     = posv_reg ? PosWidth'(where_reg) : '0;
            out_count_next   = CapWidth'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= CapWidth'(64);
            found_reg     <= 1'b0;
            ins_do_reg    <= 1'b0;
            rem_do_reg    <= 1'b0;
            rd_active_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            capacity_reg  <= capacity_next;
            found_reg     <= found_next;
            ins_do_reg    <= ins_do_next;
            rem_do_reg    <= rem_do_next;
            rd_active_reg <= rd_active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        key_reg         <= key_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        where_reg       <= where_next;
        success_reg     <= success_next;
        present_reg     <= present_next;
        posv_reg        <= posv_next;
        rd_ptr_reg      <= rd_ptr_next;
        rd_end_reg      <= rd_end_next;
        wr_addr_reg     <= wr_addr_next;
        out_success_reg <= out_success_next;
        out_present_reg <= out_present_next;
        out_pos_reg     <= out_pos_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_success  = out_success_reg;
    assign out_present  = out_present_reg;
    assign out_position = out_pos_reg;
    assign out_count    = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write to one entry in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> (lo_reg < hi_reg))
        else $error("probe with empty search window");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ((count_reg == $past(count_reg))
                     || (count_reg == $past(count_reg) + CW'(1))
                     || (count_reg == $past(count_reg) - CW'(1))))
        else $error("count moved by more than one");

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_set_table.sv =====
// sorted set table: ascending array of distinct signed values with query, insert and remove
// a transaction steps through load, a binary search of probe and compare, decide, a shift of the
//   entries that move, placing the key on insert, then the result, which may wait on m_axis_tready
// one transaction at a time
// the shift moves one entry per cycle through the single write port of the entry memory
// reset clears the count and output valid and sets capacity to 64; entries are not cleared
`default_nettype none

module sorted_set_table import sst_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // element
    input  wire logic [1:0]  s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // success, was_present, position, count_after
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata       // capacity
);

    ctrl_cmd_t           cmd;
    dp_status_t          status;
    logic                out_success;
    logic                out_present;
    logic [PosWidth-1:0] out_position;
    logic [CapWidth-1:0] out_count;

    sst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sst_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_element   (s_axis_tdata),
        .in_action    (s_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_success  (out_success),
        .out_present  (out_present),
        .out_position (out_position),
        .out_count    (out_count)
    );

    assign m_axis_tdata = {1'b0, out_count, out_position, out_present, out_success};

endmodule

`default_nettype wire

// ===== dv/set_result_checker.sv =====
// checker for the sorted set table: tracks the set, predicts each result and compares it
`timescale 1ns / 1ps

module set_result_checker import sst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element
    input  logic [1:0]  s_axis_tuser,   // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // success, was_present, position, count_after
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,      // capacity
    output int          fail_count,
    output int          outstanding
);

    localparam int Slots = 64;

    typedef struct {
        logic       success;
        logic       was_present;
        logic [5:0] position;
        logic [6:0] count_after;
    } set_result_t;

    logic signed [31:0] members [Slots];
    int unsigned        member_count;
    logic [6:0]         capacity;
    set_result_t        expected_results [$];

    // applies one request to the tracked set and returns what the block should report
    function automatic set_result_t apply_set_request(input logic [1:0] act,
                                                      input logic signed [31:0] key);
        set_result_t r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned where;
        int unsigned limit;
        int unsigned i;
        bit          found;
        lo = 0;
        hi = member_count;
        mid = 0;
        found = 1'b0;
        r.success = 1'b0;
        r.was_present = 1'b0;
        r.position = '0;
        limit = (capacity < Slots) ? capacity : Slots;
        while (lo < hi && !found)
        begin
            mid = lo + (hi - lo) / 2;
            if (members[mid] == key)
                found = 1'b1;
            else if (key > members[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        where = found ? mid : lo;
        case (act)
            ACT_QUERY:
            begin
                if (found)
                begin
                    r.success = 1'b1;
                    r.was_present = 1'b1;
                    r.position = where[5:0];
                end
            end
            ACT_INSERT:
            begin
                r.was_present = found;
                r.position = found ? where[5:0] : 6'd0;
                // the full check wins even over a value already held
                if (member_count >= limit)
                    r.success = 1'b0;
                else if (found)
                    r.success = 1'b1;
                else
                begin
                    for (i = member_count; i > where; i--)
                        members[i] = members[i - 1];
                    members[where] = key;
                    member_count++;
                    r.success = 1'b1;
                    r.position = where[5:0];
                end
            end
            ACT_REMOVE:
            begin
                if (found)
                begin
                    for (i = where; i + 1 < member_count; i++)
                        members[i] = members[i + 1];
                    member_count--;
                    r.success = 1'b1;
                    r.was_present = 1'b1;
                    r.position = where[5:0];
                end
            end
            default:
            begin
            end
        endcase
        r.count_after = member_count[6:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [6:0] want_v,
                               input logic [6:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        if (!rst_n)
        begin
            member_count = 0;
            capacity = 7'd64;
            expected_results.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_set_request(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("success", {6'd0, want.success}, {6'd0, m_axis_tdata[0]});
                    check_field("was_present", {6'd0, want.was_present},
                                {6'd0, m_axis_tdata[1]});
                    check_field("position", {1'b0, want.position}, {1'b0, m_axis_tdata[7:2]});
                    check_field("count_after", want.count_after, m_axis_tdata[14:8]);
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// testbench top: drives requests and capacity writes into the sorted set table, gives the verdict
`timescale 1ns / 1ps

module testbench import sst_pkg::*;;

    // unused action code, expected to behave as a no-op
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int IdlePct = 28;
    localparam int PhaseItems = 160;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_QUERY;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        calm = 1'b0;
    int          fail_count;
    int          outstanding;
    logic [31:0] key_pool [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sorted_set_table #(
        .DEPTH(64)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    set_result_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // random backpressure on the result side
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    // entered and left at a falling edge; valid stays high on return until the next call
    task automatic send_request(input logic [1:0] act, input logic [31:0] elem);
        while (!calm && $urandom_range(99) < IdlePct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= elem;
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // capacity is only written once the block has drained
    task automatic set_capacity(input logic [6:0] cap);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // pool_size of zero keeps the previous pool so held values can still be hit
    task automatic run_phase(input logic [6:0] cap, input int pool_size, input int ins_pct,
                             input int rem_pct, input logic quiet);
        logic [31:0] k;
        logic [1:0]  act;
        int          roll;
        set_capacity(cap);
        calm <= quiet;
        if (pool_size > 0)
        begin
            key_pool.delete();
            repeat (pool_size)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    k = roll[0] ? 32'h8000_0000 : 32'h7fff_ffff;
                else if (roll < 40)
                    k = $urandom_range(40) - 20;
                else
                    k = $urandom;
                key_pool.push_back(k);
            end
        end
        repeat (PhaseItems)
        begin
            roll = $urandom_range(99);
            if (roll < ins_pct)
                act = ACT_INSERT;
            else if (roll < ins_pct + rem_pct)
                act = ACT_REMOVE;
            else if (roll < 97)
                act = ACT_QUERY;
            else
                act = ACT_NOP;
            if ($urandom_range(99) < 85)
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                k = $urandom;
            send_request(act, k);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty set, extremes, duplicates, misses and the no-op code
        send_request(ACT_QUERY,  32'h0000_0000);
        send_request(ACT_REMOVE, 32'h0000_0005);
        send_request(ACT_NOP,    32'hffff_ffff);
        send_request(ACT_INSERT, 32'h0000_0000);
        send_request(ACT_INSERT, 32'h8000_0000);
        send_request(ACT_INSERT, 32'h7fff_ffff);
        send_request(ACT_INSERT, 32'hffff_ffff);
        send_request(ACT_INSERT, 32'h0000_0001);
        send_request(ACT_INSERT, 32'h0000_0000);
        send_request(ACT_QUERY,  32'h8000_0000);
        send_request(ACT_QUERY,  32'h7fff_ffff);
        send_request(ACT_QUERY,  32'h0000_0002);
        send_request(ACT_REMOVE, 32'hffff_ffff);
        send_request(ACT_REMOVE, 32'h0001_2345);
        send_request(ACT_INSERT, 32'h5555_5555);
        send_request(ACT_INSERT, 32'haaaa_aaaa);

        // capacity below the count: inserts refuse, queries and removes still work
        set_capacity(7'd2);
        send_request(ACT_INSERT, 32'h0000_0003);
        send_request(ACT_INSERT, 32'h5555_5555);
        send_request(ACT_QUERY,  32'h0000_0001);
        send_request(ACT_REMOVE, 32'h8000_0000);
        set_capacity(7'd0);
        send_request(ACT_INSERT, 32'h7fff_ffff);
        send_request(ACT_NOP,    32'h0000_0000);

        run_phase(7'd127, 120, 70, 10, 1'b0);
        run_phase(7'd5,     0, 25, 55, 1'b0);
        run_phase(7'd64,   40, 45, 25, 1'b0);
        run_phase(7'd0,    20, 40, 30, 1'b0);
        run_phase(7'd1,    10, 40, 30, 1'b0);
        run_phase(7'd100,  90, 50, 20, 1'b1);
        run_phase(7'd16,   30, 45, 25, 1'b0);
        run_phase(7'd64,   12, 40, 30, 1'b0);
        run_phase(7'd2,     8, 40, 30, 1'b0);
        run_phase(7'd64,  200, 65, 15, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
